>>> design/lis_pkg.sv
package lis_pkg;

    localparam int RANK_W = 12;
    localparam int LEN_W  = 13;
    localparam int REM_W  = 16;

    localparam logic [REM_W-1:0] ITEMS_MAX = {REM_W{1'b1}};

    // Running prefix maximum handed from one block cell to the next
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] acc;
    } t_link;

    // Block maximum update broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] value;
    } t_blk_upd;

endpackage

>>> design/lis_if.sv
interface lis_rank_if import lis_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output rank, input ready);
    modport sink   (input valid, input rank, output ready);
endinterface

interface lis_result_if import lis_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] best_length;
    logic [REM_W-1:0] removals;

    modport source (output valid, output best_length, output removals, input ready);
    modport sink   (input valid, input best_length, input removals, output ready);
endinterface

>>> design/lis_ram.sv
module lis_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lis_cell.sv
module lis_cell import lis_pkg::*; #(
    parameter int INDEX = 0,
    parameter int BLOCK = 64,
    parameter int LW    = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_link         i_link,
    output t_link         o_link,
    input  logic [LW-1:0] i_limit,
    input  t_blk_upd      i_upd
);

    localparam logic [31:0] LO = 32'(INDEX * BLOCK);
    localparam logic [31:0] HI = 32'((INDEX + 1) * BLOCK);

    logic [31:0]      w_lim;
    logic             w_covered;
    logic             w_in_block;
    logic [LEN_W-1:0] r_max;
    logic             r_valid;
    logic [LEN_W-1:0] r_acc;

    assign w_lim      = 32'(i_limit);
    assign w_covered  = (w_lim >= HI);
    assign w_in_block = (w_lim >= LO) && (w_lim < HI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
            // raise the block maximum when the written rank falls in this block
            if (i_upd.en && w_in_block && (i_upd.value > r_max)) begin
                r_max <= i_upd.value;
            end
        end
    end

    // fold this block in only when the whole block lies below the limit
    always_ff @(posedge i_clk) begin
        if (w_covered && (r_max > i_link.acc)) begin
            r_acc <= r_max;
        end else begin
            r_acc <= i_link.acc;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.acc   = r_acc;

endmodule

>>> design/longest_increasing_subsequence_top.sv
// Operation: whole blocks below the rank are stepped over one a cycle, then the partial block
// is read entry by entry through the store's single read port; the cell chain runs alongside.
// Throughput: one transaction at a time; the next is accepted the cycle after the result loads.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the length store, and no
// transaction is accepted until it completes.
module longest_increasing_subsequence_top import lis_pkg::*; #(
    parameter int RANKS = 4096,
    parameter int BLOCK = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lis_rank_if.sink     i_rank,
    lis_result_if.source o_result
);

    localparam int NBLOCKS = (RANKS + BLOCK - 1) / BLOCK;
    localparam int LW      = $clog2(RANKS + 1);
    localparam int AW      = $clog2(RANKS);
    localparam int CMPW    = (LW > RANK_W) ? LW : RANK_W;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SEEK   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state;
    logic [LW-1:0]    r_limit;
    logic             r_in_range;
    logic [LW-1:0]    r_base;
    logic             r_rd_pend;
    logic [LEN_W-1:0] r_scan_acc;
    logic             r_start;
    logic             r_chain_done;
    logic [LEN_W-1:0] r_chain_acc;
    logic [LW-1:0]    r_clr;
    logic [LEN_W-1:0] r_best;
    logic [REM_W-1:0] r_items;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_best;
    logic [REM_W-1:0] r_out_rem;

    logic             w_accept;
    logic [CMPW-1:0]  w_rank_ext;
    logic             w_rank_in;
    logic [LW-1:0]    w_rank_limit;
    logic             w_seek_more;
    logic             w_issue;
    logic             w_fire;
    logic [LEN_W-1:0] w_pmax;
    logic [LEN_W-1:0] w_fresh;
    logic [LEN_W-1:0] w_best_next;
    logic [REM_W-1:0] w_items_next;
    logic [REM_W-1:0] w_rem;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [LEN_W-1:0] w_wdata;
    logic [LEN_W-1:0] w_rdata;
    t_blk_upd         w_upd;
    t_link            w_link [NBLOCKS+1];

    assign i_rank.ready = (r_state == S_IDLE);
    assign w_accept     = i_rank.valid && i_rank.ready;

    assign w_rank_ext   = CMPW'(i_rank.rank);
    assign w_rank_in    = (w_rank_ext < CMPW'(RANKS));
    assign w_rank_limit = w_rank_in ? w_rank_ext[LW-1:0] : LW'(RANKS);

    assign w_seek_more  = (32'(r_base) + 32'(BLOCK)) <= 32'(r_limit);
    assign w_issue      = (r_state == S_SCAN) && (r_base < r_limit);
    assign w_fire       = (r_state == S_FINISH) && r_chain_done
                          && (!r_out_valid || o_result.ready);

    assign w_pmax       = (r_chain_acc > r_scan_acc) ? r_chain_acc : r_scan_acc;
    assign w_fresh      = w_pmax + LEN_W'(1);
    assign w_best_next  = (w_fresh > r_best) ? w_fresh : r_best;
    assign w_items_next = (r_items == ITEMS_MAX) ? r_items : r_items + REM_W'(1);
    assign w_rem        = (w_items_next > REM_W'(w_best_next))
                          ? w_items_next - REM_W'(w_best_next) : '0;

    // the clearing pass and the result write share the store's write port
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr[AW-1:0];
            w_wdata = '0;
        end else begin
            // a new length never falls below the one stored at its rank, so write it outright
            w_we    = w_fire && r_in_range;
            w_waddr = r_limit[AW-1:0];
            w_wdata = w_fresh;
        end
    end

    assign w_upd.en    = w_fire && r_in_range;
    assign w_upd.value = w_fresh;

    lis_ram #(
        .WIDTH (LEN_W),
        .DEPTH (RANKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_base[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_link[0].valid = r_start;
    assign w_link[0].acc   = '0;

    for (genvar g = 0; g < NBLOCKS; g++) begin : g_cell
        lis_cell #(
            .INDEX (g),
            .BLOCK (BLOCK),
            .LW    (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .i_limit (r_limit),
            .i_upd   (w_upd)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_start      <= 1'b0;
            r_chain_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_best       <= '0;
            r_items      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start   <= w_accept;
            r_rd_pend <= w_issue;
            if (w_accept) begin
                r_chain_done <= 1'b0;
            end else if (w_link[NBLOCKS].valid) begin
                r_chain_done <= 1'b1;
            end
            // a new result replaces the one leaving in the same cycle
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LW'(1);
                    if (r_clr == LW'(RANKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SEEK;
                    end
                end
                S_SEEK: begin
                    if (!w_seek_more) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // drain the last read before leaving
                    if (!w_issue && !r_rd_pend) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_fire) begin
                        r_best      <= w_best_next;
                        r_items     <= w_items_next;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_limit    <= w_rank_limit;
            r_in_range <= w_rank_in;
            r_base     <= '0;
            r_scan_acc <= '0;
        end else begin
            if (r_state == S_SEEK && w_seek_more) begin
                r_base <= r_base + LW'(BLOCK);
            end else if (w_issue) begin
                r_base <= r_base + LW'(1);
            end
            if (r_rd_pend && (w_rdata > r_scan_acc)) begin
                r_scan_acc <= w_rdata;
            end
        end
        if (w_link[NBLOCKS].valid) begin
            r_chain_acc <= w_link[NBLOCKS].acc;
        end
        if (w_fire) begin
            r_out_best <= w_best_next;
            r_out_rem  <= w_rem;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.best_length = r_out_best;
    assign o_result.removals    = r_out_rem;

    a_best_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_best <= $past(r_best) + LEN_W'(1)))
        else $error("best length grew by more than one");

    a_chain_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[NBLOCKS].valid |-> (r_state == S_SEEK || r_state == S_SCAN
                                   || r_state == S_FINISH))
        else $error("cell chain finished with no transaction in progress");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ($past(r_state) == S_SCAN))
        else $error("store read outside the partial block scan");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rem <= r_items))
        else $error("removal count exceeds transactions seen");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lis_pkg::*;

    localparam int          RANKS        = 4096;
    localparam int          BLOCK        = 64;
    localparam int          RANDOM_ITEMS = 1820;
    localparam int          LONG_HOLD    = 400;
    localparam int          DRAIN_CYCLES = RANKS / BLOCK + BLOCK + 16;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          MAX_PRINTED  = 50;

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic [REM_W-1:0] removals;
    } t_lis_result;

    logic i_clk;
    logic i_rst_n;

    lis_rank_if   rank_if ();
    lis_result_if result_if ();

    longest_increasing_subsequence_top #(
        .RANKS(RANKS),
        .BLOCK(BLOCK)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rank  (rank_if),
        .o_result(result_if)
    );

    // Predictor state: longest run ending on each rank, best so far, items taken
    logic [LEN_W-1:0] run_len_at [RANKS];
    logic [LEN_W-1:0] longest_run;
    logic [REM_W-1:0] ranks_taken;

    t_lis_result pending_results [$];

    bit          idle_on;
    logic        sink_hold;
    event        hold_off_go;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned input_stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void clear_predictor();
        for (int k = 0; k < RANKS; k++) run_len_at[k] = '0;
        longest_run = '0;
        ranks_taken = '0;
    endfunction

    // Prefix maximum over every rank below r, then a max update at r
    function automatic t_lis_result predict_lis(input logic [RANK_W-1:0] r);
        int unsigned below_max;
        int unsigned fresh;
        t_lis_result res;
        below_max = 0;
        for (int k = 0; k < int'(r); k++) begin
            if (run_len_at[k] > below_max) below_max = run_len_at[k];
        end
        fresh = below_max + 1;
        if (fresh > run_len_at[r]) run_len_at[r] = LEN_W'(fresh);
        if (fresh > longest_run) longest_run = LEN_W'(fresh);
        if (ranks_taken != ITEMS_MAX) ranks_taken = ranks_taken + 1'b1;
        res.best_length = longest_run;
        res.removals    = (ranks_taken > longest_run) ? ranks_taken - longest_run : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(input logic [LEN_W-1:0] got_len,
                                input logic [REM_W-1:0] got_rem);
        t_lis_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(got_len), 32'd0);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got_len !== want.best_length)
            report_mismatch("best_length", 32'(got_len), 32'(want.best_length));
        if (got_rem !== want.removals)
            report_mismatch("removals", 32'(got_rem), 32'(want.removals));
    endtask

    // Hold valid across back-to-back transactions; drop it only for a gap
    task automatic send_rank(input logic [RANK_W-1:0] r);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            rank_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rank_if.valid <= 1'b1;
        rank_if.rank  <= r;
        @(posedge i_clk);
        while (!rank_if.ready) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        pending_results.insert(pending_results.size(), predict_lis(r));
        items_sent++;
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_if.valid && result_if.ready) begin
                check_result(result_if.best_length, result_if.removals);
                stall_left = idle_on ? $urandom_range(0, 5) : 0;
            end else if (result_if.valid && stall_left > 0) begin
                stall_left--;
            end
            result_if.ready <= i_rst_n && stall_left == 0 && !sink_hold;
        end
    end

    initial begin : long_hold_off
        sink_hold = 1'b0;
        @(hold_off_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // Corners: rank zero, top rank, repeats, block boundaries, alternating bits
    task automatic test_directed_edges();
        logic [RANK_W-1:0] corner_ranks [$];
        corner_ranks = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1, 12'd2, 12'd63, 12'd64,
                         12'd65, 12'd127, 12'd128, 12'd2047, 12'd2048, 12'd4094, 12'd4095,
                         12'hAAA, 12'h555, 12'd3, 12'd1, 12'd0};
        idle_on = 1'b1;
        foreach (corner_ranks[i]) send_rank(corner_ranks[i]);
    endtask

    // Stall the result side long enough that the input backs up behind it
    task automatic test_back_pressure();
        idle_on = 1'b0;
        -> hold_off_go;
        wait (sink_hold);
        for (int i = 0; i < 8; i++) send_rank(12'd200 + 12'(i * 37));
        idle_on = 1'b1;
    endtask

    task automatic test_random_runs(input int unsigned target);
        int unsigned sent;
        int unsigned kind;
        int unsigned run_len;
        int unsigned base;
        int unsigned step_max;
        int          cur;
        sent = 0;
        while (sent < target) begin
            kind    = $urandom_range(0, 99);
            run_len = $urandom_range(4, 48);
            idle_on = ($urandom_range(0, 4) != 0);
            if (kind < 60) begin
                // ascending run: builds long chains across blocks
                cur      = $urandom_range(0, 3000);
                step_max = $urandom_range(1, 24);
                for (int i = 0; i < run_len && cur < RANKS && sent < target; i++) begin
                    send_rank(cur[RANK_W-1:0]);
                    sent++;
                    cur += $urandom_range(1, step_max);
                end
            end else if (kind < 80) begin
                // narrow window: repeats and near neighbours
                base = $urandom_range(0, RANKS - 16);
                for (int i = 0; i < run_len && sent < target; i++) begin
                    send_rank(RANK_W'(base + $urandom_range(0, 15)));
                    sent++;
                end
            end else if (kind < 90) begin
                // descending run
                cur = $urandom_range(0, RANKS - 1);
                for (int i = 0; i < run_len && cur >= 0 && sent < target; i++) begin
                    send_rank(cur[RANK_W-1:0]);
                    sent++;
                    cur -= $urandom_range(1, 64);
                end
            end else begin
                for (int i = 0; i < run_len && sent < target; i++) begin
                    send_rank(RANK_W'($urandom_range(0, RANKS - 1)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        rank_if.valid   <= 1'b0;
        rank_if.rank    <= '0;
        idle_on          = 1'b1;
        mismatches       = 0;
        items_sent       = 0;
        results_checked  = 0;
        input_stall_cycles = 0;
        cycle_count      = 0;
        clear_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_back_pressure();
        test_random_runs(RANDOM_ITEMS);
        rank_if.valid <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d ranks and checked %0d results; longest run reached %0d.",
                 items_sent, results_checked, longest_run);
        $display("Input was held back for %0d cycles, %s %0d-cycle hold-off.",
                 input_stall_cycles, "including the clearing pass and", LONG_HOLD);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
